// File: hdl/pasg_pkg.sv
package pasg_pkg;

	localparam int unsigned PHASE_BITS_DEF      = 32;
	localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
	localparam int unsigned SAMPLE_BITS_DEF     = 16;

	// Configuration register indexes and widths.
	localparam int unsigned CFG_IDX_BITS  = 2;
	localparam int unsigned CFG_DATA_BITS = 32;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TUNE_WORD  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_AMPLITUDE  = 2'd2;

	localparam int unsigned STEP_BITS = 32;
	localparam int unsigned AMP_BITS  = 16;
	// Quarter-wave entries are unsigned Q1.30, so 1.0 needs 31 bits.
	localparam int unsigned TBL_BITS  = 31;

	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
	localparam logic signed [64:0] ONE_Q30 = 65'sd1073741824;

	// Load strobes for the pipeline registers, one per stage.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
	} pasg_ctrl_t;

	// Truncating long division, used only while the table is built.
	function automatic logic [63:0] udiv64(input logic [63:0] num,
		input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Quarter-wave sine entry: sin(pi/2 * i / 2^a) in Q1.30 from a fixed-point
	// Taylor series. Evaluated only while the design elaborates.
	function automatic logic [TBL_BITS-1:0] sine_q30(input int unsigned i,
		input int unsigned a);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] den;
		logic signed [64:0] sum;
		x    = ((HALF_PI_Q60 >> a) * 64'(i)) >> 30;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed({1'b0, x});
		for (int k = 1; k < 20; k++) begin
			if (term != 64'd0) begin
				den  = 64'((2 * k) * (2 * k + 1));
				term = udiv64((term * x2) >> 30, den);
				if ((k & 1) != 0)
					sum = sum - $signed({1'b0, term});
				else
					sum = sum + $signed({1'b0, term});
			end
		end
		if (sum < 0)
			sum = '0;
		else if (sum > ONE_Q30)
			sum = ONE_Q30;
		return TBL_BITS'(sum);
	endfunction

endpackage

// File: hdl/phase_accumulator_sine_generator.sv
// Sine oscillator built on a phase accumulator. Every item on the input
// stream is one sample tick (bit 0 of s_tdata restarts the phase at zero
// first) and produces one two's complement sample on the output stream,
// amplitude times the sine of the phase, rounded and saturated. One item is
// taken per clock unless m_tready stalls the output; an accepted item passes
// through phase and table address, the registered read of the quarter-wave
// ROM (2^TABLE_ADDR_BITS + 1 entries), the amplitude multiply, and the
// round/saturate into the output register. Stalls on m_tready fill the
// pipeline before s_tready drops. The configuration port accepts a write on
// every cycle; write it only while no items are in flight.
module phase_accumulator_sine_generator #(
	parameter int unsigned PHASE_BITS      = pasg_pkg::PHASE_BITS_DEF,
	parameter int unsigned TABLE_ADDR_BITS = pasg_pkg::TABLE_ADDR_BITS_DEF,
	parameter int unsigned SAMPLE_BITS     = pasg_pkg::SAMPLE_BITS_DEF,
	localparam int unsigned OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pasg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [pasg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [7:0]                            s_tdata,  // [0] restart_phase
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [OUT_W-1:0]                      m_tdata   // sample
);

	logic                                enable_q;
	logic [pasg_pkg::STEP_BITS-1:0]      tune_word_q;
	logic [pasg_pkg::AMP_BITS-1:0]       amplitude_q;
	logic                                v_s1;
	logic                                v_s2;
	logic                                v_s3;
	logic                                v_out;
	pasg_pkg::pasg_ctrl_t                ctrl;
	logic [TABLE_ADDR_BITS:0]            addr_s1;
	logic                                neg_s1;
	logic                                en_s1;
	logic [pasg_pkg::TBL_BITS-1:0]       t_s2;
	logic                                neg_s2;
	logic                                en_s2;
	logic [SAMPLE_BITS-1:0]              sample_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			tune_word_q  <= '0;
			amplitude_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pasg_pkg::CFG_ENABLE:     enable_q     <= cfg_data[0];
				pasg_pkg::CFG_TUNE_WORD:  tune_word_q  <= cfg_data;
				pasg_pkg::CFG_AMPLITUDE:  amplitude_q  <= cfg_data[pasg_pkg::AMP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Each stage loads when it is empty or when its content moves on.
	always_comb begin
		ctrl.ld_out = v_s3 && (!v_out || m_tready);
		ctrl.ld_s3  = v_s2 && (!v_s3 || ctrl.ld_out);
		ctrl.ld_s2  = v_s1 && (!v_s2 || ctrl.ld_s3);
		s_tready    = !v_s1 || ctrl.ld_s2;
		ctrl.ld_s1  = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_out <= 1'b0;
		end else begin
			v_s1  <= ctrl.ld_s1 || (v_s1 && !ctrl.ld_s2);
			v_s2  <= ctrl.ld_s2 || (v_s2 && !ctrl.ld_s3);
			v_s3  <= ctrl.ld_s3 || (v_s3 && !ctrl.ld_out);
			v_out <= ctrl.ld_out || (v_out && !m_tready);
		end
	end

	pasg_phase #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_phase (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.restart_phase (s_tdata[0]),
		.enable        (enable_q),
		.tune_word     (tune_word_q),
		.addr_s1       (addr_s1),
		.neg_s1        (neg_s1),
		.en_s1         (en_s1)
	);

	pasg_rom #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_rom (
		.clk     (clk),
		.ctrl    (ctrl),
		.addr_s1 (addr_s1),
		.neg_s1  (neg_s1),
		.en_s1   (en_s1),
		.t_s2    (t_s2),
		.neg_s2  (neg_s2),
		.en_s2   (en_s2)
	);

	pasg_scale #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scale (
		.clk       (clk),
		.ctrl      (ctrl),
		.amplitude (amplitude_q),
		.t_s2      (t_s2),
		.neg_s2    (neg_s2),
		.en_s2     (en_s2),
		.sample_q  (sample_q)
	);

	assign m_tvalid = v_out;
	assign m_tdata  = OUT_W'(sample_q);

endmodule

// File: hdl/pasg_phase.sv
module pasg_phase #(
	parameter int unsigned PHASE_BITS      = pasg_pkg::PHASE_BITS_DEF,
	parameter int unsigned TABLE_ADDR_BITS = pasg_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pasg_pkg::pasg_ctrl_t             ctrl,
	input  logic                             restart_phase,
	input  logic                             enable,
	input  logic [pasg_pkg::STEP_BITS-1:0]   tune_word,
	output logic [TABLE_ADDR_BITS:0]         addr_s1,
	output logic                             neg_s1,
	output logic                             en_s1
);

	localparam int unsigned A = TABLE_ADDR_BITS;
	localparam logic [A:0] QSIZE = {1'b1, {A{1'b0}}};

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_cur;
	logic [PHASE_BITS-1:0] step_w;
	logic [1:0]            quad;
	logic [A-1:0]          idx;
	logic [A:0]            addr_d;

	assign step_w    = PHASE_BITS'(tune_word);
	assign phase_cur = restart_phase ? '0 : phase_q;
	assign quad      = phase_cur[PHASE_BITS-1 -: 2];
	assign idx       = phase_cur[PHASE_BITS-3 -: A];
	// Odd quadrants run the quarter wave backwards.
	assign addr_d    = quad[0] ? (QSIZE - {1'b0, idx}) : {1'b0, idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (ctrl.ld_s1) begin
			phase_q <= enable ? (phase_cur + step_w) : phase_cur;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			addr_s1 <= addr_d;
			neg_s1  <= quad[1];
			en_s1   <= enable;
		end
	end

endmodule

// File: hdl/pasg_rom.sv
module pasg_rom #(
	parameter int unsigned TABLE_ADDR_BITS = pasg_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  pasg_pkg::pasg_ctrl_t            ctrl,
	input  logic [TABLE_ADDR_BITS:0]        addr_s1,
	input  logic                            neg_s1,
	input  logic                            en_s1,
	output logic [pasg_pkg::TBL_BITS-1:0]   t_s2,
	output logic                            neg_s2,
	output logic                            en_s2
);

	localparam int unsigned DEPTH = (1 << TABLE_ADDR_BITS) + 1;

	logic [pasg_pkg::TBL_BITS-1:0] sine_rom [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		localparam logic [pasg_pkg::TBL_BITS-1:0] ENTRY =
			pasg_pkg::sine_q30(g, TABLE_ADDR_BITS);
		assign sine_rom[g] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			t_s2   <= sine_rom[addr_s1];
			neg_s2 <= neg_s1;
			en_s2  <= en_s1;
		end
	end

endmodule

// File: hdl/pasg_scale.sv
module pasg_scale #(
	parameter int unsigned SAMPLE_BITS = pasg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  pasg_pkg::pasg_ctrl_t            ctrl,
	input  logic [pasg_pkg::AMP_BITS-1:0]   amplitude,
	input  logic [pasg_pkg::TBL_BITS-1:0]   t_s2,
	input  logic                            neg_s2,
	input  logic                            en_s2,
	output logic [SAMPLE_BITS-1:0]          sample_q
);

	localparam int unsigned PROD_W = pasg_pkg::AMP_BITS + pasg_pkg::TBL_BITS;
	localparam int unsigned SH     = 46 - SAMPLE_BITS;
	localparam logic [PROD_W:0] RND_ONE = (PROD_W + 1)'(1) << (SH - 1);
	localparam logic [PROD_W:0] LIM_NEG = (PROD_W + 1)'(1) << (SAMPLE_BITS - 1);
	localparam logic [PROD_W:0] LIM_POS = LIM_NEG - (PROD_W + 1)'(1);

	logic [PROD_W-1:0]      prod_s3;
	logic                   neg_s3;
	logic                   en_s3;
	logic [PROD_W:0]        mag;
	logic [PROD_W:0]        lim;
	logic [PROD_W:0]        mag_sat;
	logic [SAMPLE_BITS-1:0] mag_lo;
	logic [SAMPLE_BITS-1:0] sample_d;

	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			prod_s3 <= PROD_W'(amplitude) * PROD_W'(t_s2);
			neg_s3  <= neg_s2;
			en_s3   <= en_s2;
		end
	end

	// Round half away from zero on the magnitude, then saturate and sign; zero while disabled.
	always_comb begin
		mag     = ({1'b0, prod_s3} + RND_ONE) >> SH;
		lim     = neg_s3 ? LIM_NEG : LIM_POS;
		mag_sat = (mag > lim) ? lim : mag;
		mag_lo  = mag_sat[SAMPLE_BITS-1:0];
		if (!en_s3)
			sample_d = '0;
		else if (neg_s3)
			sample_d = -mag_lo;
		else
			sample_d = mag_lo;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			sample_q <= sample_d;
		end
	end

endmodule

// File: hdl/pasg_checker.sv
module pasg_checker #(
	parameter int unsigned DATA_W = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// A held result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// With the output side draining, the input side never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled although output is ready");

	// Without back-pressure an accepted item shows up once it has passed the phase, ROM, multiply and output registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
		|=> m_tvalid)
		else $error("sample missing after pipeline latency");

	// Nothing is offered right after reset.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind phase_accumulator_sine_generator pasg_checker #(
	.DATA_W ($bits(m_tdata))
) u_pasg_checker (.*);
